// ===== src/klt_pkg.sv =====
// ============================================================================
// klt_pkg: shared definitions for the keyed lock table
// Holds the field widths, operation codes, sequencer states and the
// default sizes of the lock table.
// ============================================================================
package klt_pkg;

    // Fixed field widths of the request and result words.
    localparam int ID_W  = 6;
    localparam int KEY_W = 64;

    // Default table sizes.
    localparam int LOCK_ENTRIES_DEF = 16;
    localparam int REQUESTERS_DEF   = 64;

    // Operation codes.
    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_RD_REQ,
        ST_RD_ENT,
        ST_SRCH,
        ST_JOIN,
        ST_FIN
    } state_t;

endpackage

// ===== src/klt_ram.sv =====
// ============================================================================
// klt_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered, so it
// appears in the cycle after the read is issued and holds until the next read.
// ============================================================================
module klt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/keyed_lock_table_fifo_waiters.sv =====
// Sequence: a release of a held lock, a relock of the same key and a word from a sleeping waiter
// read the requester RAM, then the entry RAM; a release while idle reads only the requester RAM.
// An acquire that searches the table walks every entry, after the old lock is released first
// if one is held; one that joins a queue stops the walk as soon as the match is seen.
// Throughput: one word at a time; the key search walks the entry RAM one entry per cycle.
// Reset: asynchronous, active low; then the requester RAM is cleared before a request is taken.
// ============================================================================
// keyed_lock_table_fifo_waiters: lock manager with FIFO wait queues
// Entries (key, queue head, queue tail) live in one RAM, per-requester
// state (holding flag, next waiter, entry) in another; a sequencer reads,
// modifies and writes them back for each request word.
// ============================================================================
module keyed_lock_table_fifo_waiters #(
    parameter int LOCK_ENTRIES = klt_pkg::LOCK_ENTRIES_DEF,
    parameter int REQUESTERS   = klt_pkg::REQUESTERS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     opcode,
    input  logic [klt_pkg::ID_W-1:0] request_id,
    input  logic [klt_pkg::KEY_W-1:0] key,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     granted,
    output logic                     wake_valid,
    output logic [klt_pkg::ID_W-1:0] wake_request,
    output logic                     table_full
);

    localparam int ID_W   = klt_pkg::ID_W;
    localparam int KEY_W  = klt_pkg::KEY_W;
    localparam int SLOT_W = $clog2(LOCK_ENTRIES);
    localparam int RIDX_W = $clog2(REQUESTERS);
    localparam int ENT_W  = KEY_W + 2 * ID_W;
    localparam int REQ_W  = 2 + ID_W + SLOT_W;

    // Sequencer and request registers.
    klt_pkg::state_t       state_reg, state_next;
    logic                  op_reg, op_next;
    logic [ID_W-1:0]       rid_reg, rid_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic                  nxv_reg, nxv_next;
    logic [ID_W-1:0]       nx_reg, nx_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [ID_W-1:0]       tail_reg, tail_next;
    logic [SLOT_W:0]       scnt_reg, scnt_next;
    logic                  cmp_v_reg, cmp_v_next;
    logic [SLOT_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic                  free_v_reg, free_v_next;
    logic [SLOT_W-1:0]     free_idx_reg, free_idx_next;
    logic                  rg_reg, rg_next;
    logic                  rwv_reg, rwv_next;
    logic [ID_W-1:0]       rwr_reg, rwr_next;
    logic                  rf_reg, rf_next;
    logic                  ov_reg, ov_next;
    logic                  og_reg, og_next;
    logic                  owv_reg, owv_next;
    logic [ID_W-1:0]       owr_reg, owr_next;
    logic                  of_reg, of_next;
    logic [RIDX_W-1:0]     clr_reg, clr_next;
    logic [LOCK_ENTRIES-1:0] ev_reg, ev_next;

    // RAM ports.
    logic                  req_we, req_re;
    logic [RIDX_W-1:0]     req_waddr, req_raddr;
    logic [REQ_W-1:0]      req_wdata, req_rdata;
    logic                  ent_we, ent_re;
    logic [SLOT_W-1:0]     ent_waddr, ent_raddr;
    logic [ENT_W-1:0]      ent_wdata, ent_rdata;

    // Fields of the read data.
    logic                  rq_hv, rq_nxv;
    logic [ID_W-1:0]       rq_nx;
    logic [SLOT_W-1:0]     rq_slot;
    logic [KEY_W-1:0]      en_key;
    logic [ID_W-1:0]       en_head, en_tail;
    logic                  in_range;

    assign rq_hv   = req_rdata[REQ_W-1];
    assign rq_nxv  = req_rdata[REQ_W-2];
    assign rq_nx   = req_rdata[SLOT_W+ID_W-1 -: ID_W];
    assign rq_slot = req_rdata[SLOT_W-1:0];
    assign en_key  = ent_rdata[ENT_W-1 -: KEY_W];
    assign en_head = ent_rdata[2*ID_W-1 -: ID_W];
    assign en_tail = ent_rdata[ID_W-1:0];
    assign in_range = 32'(request_id) < 32'(REQUESTERS);

    klt_ram #(
        .WIDTH(REQ_W),
        .DEPTH(REQUESTERS)
    ) u_req_ram (
        .clk  (clk),
        .we   (req_we),
        .waddr(req_waddr),
        .wdata(req_wdata),
        .re   (req_re),
        .raddr(req_raddr),
        .rdata(req_rdata)
    );

    klt_ram #(
        .WIDTH(ENT_W),
        .DEPTH(LOCK_ENTRIES)
    ) u_ent_ram (
        .clk  (clk),
        .we   (ent_we),
        .waddr(ent_waddr),
        .wdata(ent_wdata),
        .re   (ent_re),
        .raddr(ent_raddr),
        .rdata(ent_rdata)
    );

    assign in_stall     = (state_reg != klt_pkg::ST_IDLE);
    assign out_valid    = ov_reg;
    assign granted      = og_reg;
    assign wake_valid   = owv_reg;
    assign wake_request = owr_reg;
    assign table_full   = of_reg;

    // Next state, RAM accesses and result bookkeeping.
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        rid_next      = rid_reg;
        key_next      = key_reg;
        nxv_next      = nxv_reg;
        nx_next       = nx_reg;
        slot_next     = slot_reg;
        tail_next     = tail_reg;
        scnt_next     = scnt_reg;
        cmp_v_next    = cmp_v_reg;
        cmp_idx_next  = cmp_idx_reg;
        free_v_next   = free_v_reg;
        free_idx_next = free_idx_reg;
        rg_next       = rg_reg;
        rwv_next      = rwv_reg;
        rwr_next      = rwr_reg;
        rf_next       = rf_reg;
        og_next       = og_reg;
        owv_next      = owv_reg;
        owr_next      = owr_reg;
        of_next       = of_reg;
        clr_next      = clr_reg;
        ev_next       = ev_reg;
        req_we        = 1'b0;
        req_waddr     = '0;
        req_wdata     = '0;
        req_re        = 1'b0;
        req_raddr     = '0;
        ent_we        = 1'b0;
        ent_waddr     = '0;
        ent_wdata     = '0;
        ent_re        = 1'b0;
        ent_raddr     = '0;

        // The output word leaves when the receiver takes it.
        ov_next = ov_reg && out_stall;

        case (state_reg)
            klt_pkg::ST_CLR:
            begin
                req_we    = 1'b1;
                req_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == RIDX_W'(REQUESTERS - 1))
                begin
                    state_next = klt_pkg::ST_IDLE;
                end
            end

            klt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next  = opcode;
                    rid_next = request_id;
                    key_next = key;
                    rg_next  = 1'b0;
                    rwv_next = 1'b0;
                    rwr_next = '0;
                    rf_next  = 1'b0;
                    if (in_range)
                    begin
                        req_re     = 1'b1;
                        req_raddr  = RIDX_W'(request_id);
                        state_next = klt_pkg::ST_RD_REQ;
                    end
                    else
                    begin
                        state_next = klt_pkg::ST_FIN;
                    end
                end
            end

            klt_pkg::ST_RD_REQ:
            begin
                nxv_next  = rq_nxv;
                nx_next   = rq_nx;
                slot_next = rq_slot;
                scnt_next    = '0;
                cmp_v_next   = 1'b0;
                free_v_next  = 1'b0;
                if (rq_hv)
                begin
                    ent_re     = 1'b1;
                    ent_raddr  = rq_slot;
                    state_next = klt_pkg::ST_RD_ENT;
                end
                else if (op_reg == klt_pkg::OP_RELEASE)
                begin
                    state_next = klt_pkg::ST_FIN;
                end
                else
                begin
                    state_next = klt_pkg::ST_SRCH;
                end
            end

            klt_pkg::ST_RD_ENT:
            begin
                if (en_head != rid_reg)
                begin
                    // A sleeping waiter is ignored.
                    state_next = klt_pkg::ST_FIN;
                end
                else if (op_reg == klt_pkg::OP_ACQUIRE && en_key == key_reg)
                begin
                    rg_next    = 1'b1;
                    state_next = klt_pkg::ST_FIN;
                end
                else
                begin
                    // Release the held lock; hand it to the next waiter if any.
                    req_we    = 1'b1;
                    req_waddr = RIDX_W'(rid_reg);
                    req_wdata = {1'b0, nxv_reg, nx_reg, slot_reg};
                    if (nxv_reg)
                    begin
                        ent_we    = 1'b1;
                        ent_waddr = slot_reg;
                        ent_wdata = {en_key, nx_reg, en_tail};
                        rwv_next  = 1'b1;
                        rwr_next  = nx_reg;
                    end
                    else
                    begin
                        ev_next[slot_reg] = 1'b0;
                    end
                    if (op_reg == klt_pkg::OP_RELEASE)
                    begin
                        state_next = klt_pkg::ST_FIN;
                    end
                    else
                    begin
                        state_next = klt_pkg::ST_SRCH;
                    end
                end
            end

            klt_pkg::ST_SRCH:
            begin
                // Issue one entry read per cycle; compare the previous one.
                if (scnt_reg < (SLOT_W+1)'(LOCK_ENTRIES))
                begin
                    ent_re    = 1'b1;
                    ent_raddr = scnt_reg[SLOT_W-1:0];
                    scnt_next = scnt_reg + 1'b1;
                end
                cmp_v_next   = scnt_reg < (SLOT_W+1)'(LOCK_ENTRIES);
                cmp_idx_next = scnt_reg[SLOT_W-1:0];
                if (cmp_v_reg)
                begin
                    if (ev_reg[cmp_idx_reg] && en_key == key_reg)
                    begin
                        // Join the tail of the queue and fetch the old tail.
                        ent_we     = 1'b1;
                        ent_waddr  = cmp_idx_reg;
                        ent_wdata  = {key_reg, en_head, rid_reg};
                        req_we     = 1'b1;
                        req_waddr  = RIDX_W'(rid_reg);
                        req_wdata  = {1'b1, 1'b0, {ID_W{1'b0}}, cmp_idx_reg};
                        req_re     = 1'b1;
                        req_raddr  = RIDX_W'(en_tail);
                        tail_next  = en_tail;
                        state_next = klt_pkg::ST_JOIN;
                    end
                    else if (!ev_reg[cmp_idx_reg] && !free_v_reg)
                    begin
                        free_v_next   = 1'b1;
                        free_idx_next = cmp_idx_reg;
                    end
                end
                else if (scnt_reg == (SLOT_W+1)'(LOCK_ENTRIES))
                begin
                    // No match: allocate the lowest free entry.
                    if (free_v_reg)
                    begin
                        ev_next[free_idx_reg] = 1'b1;
                        ent_we    = 1'b1;
                        ent_waddr = free_idx_reg;
                        ent_wdata = {key_reg, rid_reg, rid_reg};
                        req_we    = 1'b1;
                        req_waddr = RIDX_W'(rid_reg);
                        req_wdata = {1'b1, 1'b0, {ID_W{1'b0}}, free_idx_reg};
                        rg_next   = 1'b1;
                    end
                    else
                    begin
                        rf_next = 1'b1;
                    end
                    state_next = klt_pkg::ST_FIN;
                end
            end

            klt_pkg::ST_JOIN:
            begin
                // Link the new waiter behind the old tail.
                req_we     = 1'b1;
                req_waddr  = RIDX_W'(tail_reg);
                req_wdata  = {rq_hv, 1'b1, rid_reg, rq_slot};
                state_next = klt_pkg::ST_FIN;
            end

            klt_pkg::ST_FIN:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    og_next    = rg_reg;
                    owv_next   = rwv_reg;
                    owr_next   = rwr_reg;
                    of_next    = rf_reg;
                    state_next = klt_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = klt_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= klt_pkg::ST_CLR;
            clr_reg    <= '0;
            ev_reg     <= '0;
            ov_reg     <= 1'b0;
            scnt_reg   <= '0;
            cmp_v_reg  <= 1'b0;
            free_v_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            ev_reg     <= ev_next;
            ov_reg     <= ov_next;
            scnt_reg   <= scnt_next;
            cmp_v_reg  <= cmp_v_next;
            free_v_reg <= free_v_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        rid_reg      <= rid_next;
        key_reg      <= key_next;
        nxv_reg      <= nxv_next;
        nx_reg       <= nx_next;
        slot_reg     <= slot_next;
        tail_reg     <= tail_next;
        cmp_idx_reg  <= cmp_idx_next;
        free_idx_reg <= free_idx_next;
        rg_reg       <= rg_next;
        rwv_reg      <= rwv_next;
        rwr_reg      <= rwr_next;
        rf_reg       <= rf_next;
        og_reg       <= og_next;
        owv_reg      <= owv_next;
        owr_reg      <= owr_next;
        of_reg       <= of_next;
    end

`ifndef SYNTHESIS
    // A word is never granted and refused for a full table at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(granted && table_full))
        else $error("granted and table_full both set");

    // The woken requester reads zero unless a wake is reported.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !wake_valid) |-> (wake_request == '0))
        else $error("wake_request set without wake_valid");

    // No request is taken while the requester RAM is being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == klt_pkg::ST_CLR) |-> in_stall)
        else $error("request accepted during clearing pass");
`endif

endmodule
